// ----- hw/rtl/vtgd_pkg.sv -----
// ----------------------------------------------------------------------------
// vtgd_pkg
// Shared types and constants for the vector tile geometry decoder.
// ----------------------------------------------------------------------------
package vtgd_pkg;

    // Default width of the running coordinate sums.
    localparam int COORD_BITS_DEF = 32;

    // Geometry type register value after reset (points).
    localparam logic [2:0] GEOM_TYPE_RESET = 3'd1;

    typedef struct packed {
        logic [31:0] command_word;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic               part_first;
        logic               part_last;
        logic [29:0]        part_points;
        logic [2:0]         error_code;
        logic               stream_end;
    } t_out_item;

    // One decode step's outcome: whether a result exists and its fields.
    typedef struct packed {
        logic      have;
        t_out_item item;
    } t_step_res;

endpackage

// ----- hw/rtl/vector_tile_geometry_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// vector_tile_geometry_decoder_unit
// Decodes a vector tile geometry command stream into absolute points.
// ----------------------------------------------------------------------------
// One command word per transfer goes in; at most one point or status result
// comes out. The unit takes a new word every cycle unless the input stalls: a
// word is captured in an input register, decoded by the phase machine once
// the output register can take a load, and its result lands there. The phase
// machine with its adders for the running x and y sums sets that rate. Input
// stall rises only when both the input and output registers are full and the
// downstream side stalls. Words that cause no result (moveto commands, x
// deltas, words after an error) pass through without occupying the output.
// Every geometry ends with a result carrying stream_end; an error code there
// reports the first error seen, an illegal geometry type, a truncated stream
// or a polygon with no closed ring. The user must write the geometry type
// register via the config port while idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
module vector_tile_geometry_decoder_unit #(
    parameter int COORD_BITS = vtgd_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_wdata,
    // command words in
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vtgd_pkg::t_in_item  i_in_item,
    // results out
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vtgd_pkg::t_out_item o_out_item
);

    logic [2:0]          r_geom_type;
    logic                r_in_valid;
    logic                n_in_valid;
    vtgd_pkg::t_in_item  r_in_item;
    logic                in_take;
    logic                advance;
    logic                can_load;
    vtgd_pkg::t_step_res res;

    // geometry type register, kept across streams
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom_type <= vtgd_pkg::GEOM_TYPE_RESET;
        end else if (i_cfg_we) begin
            r_geom_type <= i_cfg_wdata;
        end
    end

    // the held word advances only when the output register can take a load, result or not
    assign advance    = r_in_valid && can_load;
    assign o_in_stall = r_in_valid && !can_load;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    vtgd_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom_type (r_geom_type),
        .i_step      (advance),
        .i_item      (r_in_item),
        .o_res       (res)
    );

    vtgd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && res.have),
        .i_item      (res.item),
        .i_out_stall (i_out_stall),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled without a full, stalled output");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res.have |=> o_out_valid)
        else $error("decoded result did not reach the output register");

    a_held_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item))
        else $error("waiting word was dropped or overwritten");

endmodule

// ----- hw/rtl/vtgd_decode.sv -----
// ----------------------------------------------------------------------------
// vtgd_decode
// Geometry command phase machine, running delta sums and error tracking.
// ----------------------------------------------------------------------------
module vtgd_decode #(
    parameter int COORD_BITS = vtgd_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_geom_type,
    input  logic               i_step,
    input  vtgd_pkg::t_in_item i_item,
    output vtgd_pkg::t_step_res o_res
);

    localparam logic [2:0] PH_CMD    = 3'd0;
    localparam logic [2:0] PH_MX     = 3'd1;
    localparam logic [2:0] PH_MY     = 3'd2;
    localparam logic [2:0] PH_LTCMD  = 3'd3;
    localparam logic [2:0] PH_LX     = 3'd4;
    localparam logic [2:0] PH_LY     = 3'd5;
    localparam logic [2:0] PH_CLOSE  = 3'd6;
    localparam logic [2:0] PH_UNUSED = 3'd7;

    localparam logic [2:0] GEOM_POINTS  = 3'd1;
    localparam logic [2:0] GEOM_POLYGON = 3'd3;

    localparam logic [2:0] CMD_MOVETO = 3'd1;
    localparam logic [2:0] CMD_LINETO = 3'd2;
    localparam logic [31:0] WORD_SINGLE_MOVETO = 32'd9;
    localparam logic [31:0] WORD_SINGLE_CLOSE  = 32'd15;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NOT_MOVETO   = 3'd1;
    localparam logic [2:0] ERR_RING_START   = 3'd2;
    localparam logic [2:0] ERR_NO_LINETO    = 3'd3;
    localparam logic [2:0] ERR_NO_CLOSE     = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd5;
    localparam logic [2:0] ERR_NO_RINGS     = 3'd6;
    localparam logic [2:0] ERR_BAD_TYPE     = 3'd7;

    logic [2:0]            r_phase,      n_phase;
    logic [28:0]           r_count,      n_count;
    logic [COORD_BITS-1:0] r_x,          n_x;
    logic [COORD_BITS-1:0] r_y,          n_y;
    logic [COORD_BITS-1:0] r_first_x,    n_first_x;
    logic [COORD_BITS-1:0] r_first_y,    n_first_y;
    logic [29:0]           r_total,      n_total;
    logic                  r_rings,      n_rings;
    logic                  r_err_latched, n_err_latched;
    logic [2:0]            r_err_kept,   n_err_kept;

    logic [31:0]           w;
    logic                  last;
    logic [63:0]           w_ext;
    logic [COORD_BITS-1:0] delta;
    logic [COORD_BITS-1:0] x_new;
    logic [COORD_BITS-1:0] y_new;
    logic [28:0]           cmd_cnt;
    logic [28:0]           cnt_dec;
    logic [29:0]           lt_total;
    logic                  poly;
    logic                  type_ok;
    logic                  fault;
    logic                  have;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic                  pf;
    logic                  pl;
    logic [29:0]           pp;
    logic [2:0]            ec;
    logic signed [63:0]    rx_wide;
    logic signed [63:0]    ry_wide;

    assign w       = i_item.command_word;
    assign last    = i_item.last_word;
    // zigzag: (w >> 1) ^ -(w & 1), kept at sum width
    assign w_ext   = {33'd0, w[31:1]};
    assign delta   = w_ext[COORD_BITS-1:0] ^ {COORD_BITS{w[0]}};
    assign x_new   = r_x + delta;
    assign y_new   = r_y + delta;
    assign cmd_cnt = w[31:3];
    assign cnt_dec = (r_count != 29'd0) ? r_count - 29'd1 : r_count;
    assign poly    = (i_geom_type == GEOM_POLYGON);
    assign type_ok = (i_geom_type >= 3'd1) && (i_geom_type <= GEOM_POLYGON);
    assign lt_total = 30'(cmd_cnt) + 30'd1 + 30'(poly);

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_x           = r_x;
        n_y           = r_y;
        n_first_x     = r_first_x;
        n_first_y     = r_first_y;
        n_total       = r_total;
        n_rings       = r_rings;
        n_err_latched = r_err_latched;
        n_err_kept    = r_err_kept;
        have  = 1'b0;
        fault = 1'b0;
        rx    = '0;
        ry    = '0;
        pf    = 1'b0;
        pl    = 1'b0;
        pp    = '0;
        ec    = ERR_NONE;

        if (r_err_latched) begin
            if (last) begin
                have = 1'b1;
                ec   = r_err_kept;
            end
        end else if (!type_ok) begin
            // illegal type: word ignored, code shows only on the last word
            ec    = ERR_BAD_TYPE;
        end else begin
            unique case (r_phase)
                PH_MX: begin
                    n_x     = x_new;
                    n_phase = PH_MY;
                end
                PH_MY: begin
                    n_y = y_new;
                    if (i_geom_type == GEOM_POINTS) begin
                        have    = 1'b1;
                        rx      = r_x;
                        ry      = y_new;
                        pf      = 1'b1;
                        pl      = 1'b1;
                        pp      = 30'd1;
                        n_count = cnt_dec;
                        n_phase = (cnt_dec != 29'd0) ? PH_MX : PH_CMD;
                    end else begin
                        n_first_x = r_x;
                        n_first_y = y_new;
                        n_phase   = PH_LTCMD;
                    end
                end
                PH_LTCMD: begin
                    if (w[2:0] != CMD_LINETO) begin
                        fault = 1'b1;
                        ec    = ERR_NO_LINETO;
                    end else begin
                        n_count = cmd_cnt;
                        n_total = lt_total;
                        have    = 1'b1;
                        rx      = r_first_x;
                        ry      = r_first_y;
                        pf      = 1'b1;
                        pp      = lt_total;
                        if (cmd_cnt == 29'd0) begin
                            pl      = !poly;
                            n_phase = poly ? PH_CLOSE : PH_CMD;
                            if (!poly) begin
                                n_rings = 1'b1;
                            end
                        end else begin
                            n_phase = PH_LX;
                        end
                    end
                end
                PH_LX: begin
                    n_x     = x_new;
                    n_phase = PH_LY;
                end
                PH_LY: begin
                    n_y     = y_new;
                    have    = 1'b1;
                    rx      = r_x;
                    ry      = y_new;
                    pp      = r_total;
                    n_count = cnt_dec;
                    if (cnt_dec != 29'd0) begin
                        n_phase = PH_LX;
                    end else if (poly) begin
                        n_phase = PH_CLOSE;
                    end else begin
                        pl      = 1'b1;
                        n_rings = 1'b1;
                        n_phase = PH_CMD;
                    end
                end
                PH_CLOSE: begin
                    if (w != WORD_SINGLE_CLOSE) begin
                        fault = 1'b1;
                        ec    = ERR_NO_CLOSE;
                    end else begin
                        have    = 1'b1;
                        rx      = r_first_x;
                        ry      = r_first_y;
                        pl      = 1'b1;
                        pp      = r_total;
                        n_rings = 1'b1;
                        n_phase = PH_CMD;
                    end
                end
                default: begin
                    // expect command; the unused code behaves the same
                    if (i_geom_type == GEOM_POINTS) begin
                        if (w[2:0] != CMD_MOVETO) begin
                            fault = 1'b1;
                            ec    = ERR_NOT_MOVETO;
                        end else begin
                            n_count = cmd_cnt;
                            n_phase = (cmd_cnt != 29'd0) ? PH_MX : PH_CMD;
                        end
                    end else begin
                        if (w != WORD_SINGLE_MOVETO) begin
                            fault = 1'b1;
                            ec    = ERR_RING_START;
                        end else begin
                            n_phase = PH_MX;
                        end
                    end
                end
            endcase
        end

        // a fresh error wipes the point fields and latches its code
        if (fault) begin
            n_err_latched = 1'b1;
            n_err_kept    = ec;
            have = 1'b1;
            rx   = '0;
            ry   = '0;
            pf   = 1'b0;
            pl   = 1'b0;
            pp   = '0;
        end

        if (last) begin
            have = 1'b1;
            if (!n_err_latched) begin
                if (n_phase != PH_CMD) begin
                    ec = ERR_TRUNCATED;
                end else if (poly && !n_rings) begin
                    ec = ERR_NO_RINGS;
                end
            end
            n_phase       = PH_CMD;
            n_count       = '0;
            n_x           = '0;
            n_y           = '0;
            n_first_x     = '0;
            n_first_y     = '0;
            n_total       = '0;
            n_rings       = 1'b0;
            n_err_latched = 1'b0;
            n_err_kept    = ERR_NONE;
        end
    end

    assign rx_wide = 64'(signed'(rx));
    assign ry_wide = 64'(signed'(ry));

    always_comb begin
        o_res.have             = have;
        o_res.item.coord_x     = rx_wide[31:0];
        o_res.item.coord_y     = ry_wide[31:0];
        o_res.item.part_first  = pf;
        o_res.item.part_last   = pl;
        o_res.item.part_points = pp;
        o_res.item.error_code  = ec;
        o_res.item.stream_end  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_CMD;
            r_count       <= '0;
            r_x           <= '0;
            r_y           <= '0;
            r_first_x     <= '0;
            r_first_y     <= '0;
            r_total       <= '0;
            r_rings       <= 1'b0;
            r_err_latched <= 1'b0;
            r_err_kept    <= ERR_NONE;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_x           <= n_x;
            r_y           <= n_y;
            r_first_x     <= n_first_x;
            r_first_y     <= n_first_y;
            r_total       <= n_total;
            r_rings       <= n_rings;
            r_err_latched <= n_err_latched;
            r_err_kept    <= n_err_kept;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && last |=> r_phase == PH_CMD && !r_err_latched && r_x == '0 && r_y == '0)
        else $error("stream state not cleared after last word");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && last |-> o_res.have && o_res.item.stream_end)
        else $error("last word produced no ending result");

    a_err_code_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_latched == (r_err_kept != ERR_NONE))
        else $error("latched error and kept code disagree");

    a_no_unused_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_UNUSED)
        else $error("phase machine reached the unused code");

endmodule

// ----- hw/rtl/vtgd_out_reg.sv -----
// ----------------------------------------------------------------------------
// vtgd_out_reg
// Result register holding one decoded item for the downstream side.
// ----------------------------------------------------------------------------
module vtgd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  vtgd_pkg::t_out_item i_item,
    input  logic                i_out_stall,
    output logic                o_can_load,
    output logic                o_out_valid,
    output vtgd_pkg::t_out_item o_out_item
);

    logic                r_valid;
    logic                n_valid;
    vtgd_pkg::t_out_item r_item;

    // free when empty or when the held item transfers this cycle
    assign o_can_load = !r_valid || !i_out_stall;
    assign n_valid    = i_load || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule
